@@ rtl/core/hblm_pkg.sv @@
// Shared constants, state encoding and control structs for the heading-binned lift map.
package hblm_pkg;

    localparam int NUM_BINS_DEF = 36;

    localparam int HEAD_W = 12;
    localparam int LIFT_W = 16;
    localparam int RATE_W = 16;
    localparam int TIME_W = 32;
    localparam int FILT_W = 24;
    localparam int PEAK_W = 15;

    localparam int FULL_TURN = 3600;
    localparam int HALF_TURN = 1800;

    localparam logic signed [LIFT_W-1:0] LIFT_FLOOR = 16'sd1000;

    localparam int NUMER_W    = 27;
    localparam int MAG_W      = 26;
    localparam int DIV5_SHIFT = 29;
    localparam int RECIP5_W   = 27;
    localparam int PROD5_W    = MAG_W + RECIP5_W;
    localparam logic [RECIP5_W-1:0] DIV5_RECIP =
        RECIP5_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_NUM,
        ST_FILT_MUL,
        ST_FILT_DIV,
        ST_WALK_MUL,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_SCAN_RD,
        ST_SCAN_END,
        ST_EMIT_MUL,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic filt_direct;
        logic filt_num;
        logic filt_mul;
        logic filt_div;
        logic bin_mul;
        logic bin_rd;
        logic walk_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_cmp;
        logic emit_init;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fix_ok;
        logic filt_zero;
        logic walk_more;
        logic walk_empty;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } status_t;

endpackage

@@ rtl/core/hblm_ctrl.sv @@
// Sequencer for filter update, bin walk, peak rescan and result emission.
module hblm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    input  hblm_pkg::status_t status,
    output hblm_pkg::cmd_t    cmd
);

    hblm_pkg::state_t state_reg;
    hblm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hblm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            hblm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (action)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (status.fix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = hblm_pkg::ST_FILT_NUM;
                    end
                end
            end
            hblm_pkg::ST_FILT_NUM:
            begin
                if (status.filt_zero)
                begin
                    cmd.filt_direct = 1'b1;
                    state_next      = hblm_pkg::ST_WALK_MUL;
                end
                else
                begin
                    cmd.filt_num = 1'b1;
                    state_next   = hblm_pkg::ST_FILT_MUL;
                end
            end
            hblm_pkg::ST_FILT_MUL:
            begin
                cmd.filt_mul = 1'b1;
                state_next   = hblm_pkg::ST_FILT_DIV;
            end
            hblm_pkg::ST_FILT_DIV:
            begin
                cmd.filt_div = 1'b1;
                state_next   = hblm_pkg::ST_WALK_MUL;
            end
            hblm_pkg::ST_WALK_MUL:
            begin
                if (status.walk_more)
                begin
                    cmd.bin_mul = 1'b1;
                    state_next  = hblm_pkg::ST_WALK_RD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = hblm_pkg::ST_SCAN_RD;
                end
            end
            hblm_pkg::ST_WALK_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = hblm_pkg::ST_WALK_WR;
            end
            hblm_pkg::ST_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = hblm_pkg::ST_WALK_MUL;
            end
            hblm_pkg::ST_SCAN_RD:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.scan_cmp = 1'b1;
                if (status.scan_done)
                begin
                    state_next = hblm_pkg::ST_SCAN_END;
                end
            end
            hblm_pkg::ST_SCAN_END:
            begin
                cmd.scan_cmp  = 1'b1;
                cmd.emit_init = 1'b1;
                state_next    = status.walk_empty ? hblm_pkg::ST_IDLE
                                                  : hblm_pkg::ST_EMIT_MUL;
            end
            hblm_pkg::ST_EMIT_MUL:
            begin
                cmd.bin_mul = 1'b1;
                state_next  = hblm_pkg::ST_EMIT_RD;
            end
            hblm_pkg::ST_EMIT_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = hblm_pkg::ST_EMIT_OUT;
            end
            hblm_pkg::ST_EMIT_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.emit_last ? hblm_pkg::ST_IDLE
                                                    : hblm_pkg::ST_EMIT_MUL;
                end
            end
            default:
            begin
                state_next = hblm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/hblm_dp.sv @@
// Datapath: fix registers, turn-rate filter, bin store, walk, peak scan and output register.
module hblm_dp #(
    parameter int NUM_BINS = hblm_pkg::NUM_BINS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  circling,
    input  logic        [hblm_pkg::TIME_W-1:0]    fix_time,
    input  logic signed [hblm_pkg::RATE_W-1:0]    turn_rate,
    input  logic        [hblm_pkg::HEAD_W-1:0]    heading,
    input  logic signed [hblm_pkg::LIFT_W-1:0]    lift,
    input  hblm_pkg::cmd_t                        cmd,
    output hblm_pkg::status_t                     status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [$clog2(NUM_BINS)-1:0]    bin_index,
    output logic signed [hblm_pkg::LIFT_W-1:0]    bin_lift,
    output logic        [hblm_pkg::PEAK_W-1:0]    lift_peak,
    output logic                                  left_turn,
    output logic                                  last
);

    localparam int HEAD_W      = hblm_pkg::HEAD_W;
    localparam int LIFT_W      = hblm_pkg::LIFT_W;
    localparam int FILT_W      = hblm_pkg::FILT_W;
    localparam int BIN_W       = hblm_pkg::FULL_TURN / NUM_BINS;
    localparam int IDX_W       = $clog2(NUM_BINS);
    localparam int WALK_MAX    = hblm_pkg::HALF_TURN / BIN_W + 1;
    localparam int CNT_W       = $clog2(WALK_MAX + 1);
    localparam int BIN_SHIFT   = HEAD_W + $clog2(BIN_W);
    localparam int BIN_RECIP_W = HEAD_W + 2;
    localparam int BIN_PROD_W  = HEAD_W + BIN_RECIP_W;
    localparam int Q_W         = BIN_PROD_W - BIN_SHIFT;
    localparam logic [BIN_RECIP_W-1:0] BIN_RECIP =
        BIN_RECIP_W'(((64'd1 << BIN_SHIFT) + 64'(BIN_W) - 64'd1) / 64'(BIN_W));
    localparam logic [HEAD_W-1:0] FULL_H   = HEAD_W'(hblm_pkg::FULL_TURN);
    localparam logic [HEAD_W-1:0] BIN_W_H  = HEAD_W'(BIN_W);
    localparam logic [HEAD_W-1:0] HALF_BIN = HEAD_W'(BIN_W / 2);
    localparam logic signed [HEAD_W:0] FULL_S = (HEAD_W + 1)'(hblm_pkg::FULL_TURN);
    localparam logic signed [HEAD_W:0] HALF_S = (HEAD_W + 1)'(hblm_pkg::HALF_TURN);

    // persistent state
    logic signed [FILT_W-1:0]          filt_reg;
    logic        [hblm_pkg::TIME_W-1:0] prev_time_reg;
    logic        [HEAD_W-1:0]          prev_heading_reg;
    logic                              prev_valid_reg;
    logic signed [LIFT_W-1:0]          peak_reg;
    logic        [NUM_BINS-1:0]        bin_valid_reg;
    logic signed [LIFT_W-1:0]          mem [NUM_BINS];

    // per-fix registers
    logic signed [hblm_pkg::RATE_W-1:0] rate_reg;
    logic        [HEAD_W-1:0]           heading_reg;
    logic signed [LIFT_W-1:0]           lift_reg;
    logic        [HEAD_W-1:0]           h_start_reg;
    logic        [HEAD_W-1:0]           h_reg;
    logic                               first_reg;
    logic        [CNT_W-1:0]            n_reg;
    logic        [CNT_W-1:0]            k_reg;
    logic        [hblm_pkg::MAG_W-1:0]  mag_reg;
    logic                               neg_reg;
    logic        [hblm_pkg::PROD5_W-1:0] prod5_reg;
    logic        [BIN_PROD_W-1:0]       bin_prod_reg;
    logic        [IDX_W-1:0]            idx_reg;
    logic signed [LIFT_W-1:0]           rd_data_reg;
    logic                               rd_valid_reg;
    logic        [IDX_W-1:0]            scan_cnt_reg;
    logic                               scan_pend_reg;

    // output register
    logic                               out_valid_reg;
    logic        [IDX_W-1:0]            bin_index_reg;
    logic signed [LIFT_W-1:0]           bin_lift_reg;
    logic        [hblm_pkg::PEAK_W-1:0] lift_peak_reg;
    logic                               left_reg;
    logic                               last_reg;

    logic        [HEAD_W-1:0]           heading_red;
    logic signed [hblm_pkg::NUMER_W-1:0] filt_x4;
    logic signed [hblm_pkg::NUMER_W-1:0] rate_x256;
    logic signed [hblm_pkg::NUMER_W-1:0] numer;
    logic signed [hblm_pkg::NUMER_W-1:0] numer_adj;
    logic        [FILT_W-1:0]           quot5;
    logic                               left;
    logic signed [HEAD_W:0]             d_raw;
    logic signed [HEAD_W:0]             d_wrap;
    logic                               dir_ok;
    logic        [HEAD_W:0]             h_up_sum;
    logic        [HEAD_W-1:0]           h_up;
    logic        [HEAD_W-1:0]           h_dn;
    logic        [HEAD_W-1:0]           h_step;
    logic        [Q_W-1:0]              bin_q;
    logic        [IDX_W-1:0]            bin_idx;
    logic        [IDX_W-1:0]            rd_addr;
    logic signed [LIFT_W-1:0]           rd_val;
    logic signed [LIFT_W:0]             avg_sum;
    logic signed [LIFT_W-1:0]           wr_val;

    assign heading_red = (heading >= FULL_H) ? heading - FULL_H : heading;

    assign filt_x4   = {filt_reg[FILT_W-1], filt_reg, 2'b00};
    assign rate_x256 = {{3{rate_reg[hblm_pkg::RATE_W-1]}}, rate_reg, 8'h00};
    assign numer     = filt_x4 + rate_x256;
    assign numer_adj = numer[hblm_pkg::NUMER_W-1] ? (-numer + 27'sd4) : numer;
    assign quot5     = prod5_reg[hblm_pkg::PROD5_W-1:hblm_pkg::DIV5_SHIFT];

    assign left = filt_reg[FILT_W-1];

    assign d_raw  = $signed({1'b0, heading_reg}) - $signed({1'b0, h_reg});
    always_comb
    begin
        if (d_raw > HALF_S)
        begin
            d_wrap = d_raw - FULL_S;
        end
        else if (d_raw <= -HALF_S)
        begin
            d_wrap = d_raw + FULL_S;
        end
        else
        begin
            d_wrap = d_raw;
        end
    end
    assign dir_ok = left ? (d_wrap < 0) : (d_wrap >= 0);

    assign h_up_sum = {1'b0, h_reg} + {1'b0, BIN_W_H};
    assign h_up     = (h_up_sum >= {1'b0, FULL_H}) ? HEAD_W'(h_up_sum - {1'b0, FULL_H})
                                                   : h_up_sum[HEAD_W-1:0];
    assign h_dn     = (h_reg >= BIN_W_H) ? h_reg - BIN_W_H : h_reg + (FULL_H - BIN_W_H);
    assign h_step   = left ? h_dn : h_up;

    assign bin_q   = bin_prod_reg[BIN_PROD_W-1:BIN_SHIFT];
    assign bin_idx = (bin_q > Q_W'(NUM_BINS - 1)) ? IDX_W'(NUM_BINS - 1) : bin_q[IDX_W-1:0];
    assign rd_addr = cmd.scan_rd ? scan_cnt_reg : bin_idx;

    assign rd_val  = rd_valid_reg ? rd_data_reg : '0;
    assign avg_sum = {rd_val[LIFT_W-1], rd_val} + {lift_reg[LIFT_W-1], lift_reg};
    assign wr_val  = (first_reg || rd_val == '0) ? lift_reg : avg_sum[LIFT_W:1];

    always_comb
    begin
        status            = '0;
        status.fix_ok     = circling && (fix_time > prev_time_reg);
        status.filt_zero  = (filt_reg == '0);
        status.walk_more  = first_reg ? (n_reg == '0)
                                      : ((n_reg < CNT_W'(WALK_MAX)) && dir_ok);
        status.walk_empty = (n_reg == '0);
        status.scan_done  = (scan_cnt_reg == IDX_W'(NUM_BINS - 1));
        status.out_free   = !out_valid_reg || !out_stall;
        status.emit_last  = (CNT_W'(k_reg + 1'b1) == n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg         <= '0;
            prev_time_reg    <= '0;
            prev_heading_reg <= '0;
            prev_valid_reg   <= 1'b0;
            peak_reg         <= hblm_pkg::LIFT_FLOOR;
            bin_valid_reg    <= '0;
            first_reg        <= 1'b0;
            n_reg            <= '0;
            k_reg            <= '0;
            rd_valid_reg     <= 1'b0;
            scan_cnt_reg     <= '0;
            scan_pend_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                filt_reg      <= '0;
                peak_reg      <= hblm_pkg::LIFT_FLOOR;
                bin_valid_reg <= '0;
            end
            if (cmd.load)
            begin
                prev_time_reg    <= fix_time;
                prev_heading_reg <= heading_red;
                prev_valid_reg   <= 1'b1;
                first_reg        <= !prev_valid_reg;
                n_reg            <= '0;
            end
            if (cmd.filt_direct)
            begin
                filt_reg <= {rate_reg, 8'h00};
            end
            if (cmd.filt_div)
            begin
                filt_reg <= neg_reg ? -$signed(quot5) : $signed(quot5);
            end
            if (cmd.bin_rd || cmd.scan_rd)
            begin
                rd_valid_reg <= bin_valid_reg[rd_addr];
            end
            if (cmd.walk_wr)
            begin
                bin_valid_reg[idx_reg] <= 1'b1;
                n_reg                  <= n_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                peak_reg      <= hblm_pkg::LIFT_FLOOR;
                scan_cnt_reg  <= '0;
                scan_pend_reg <= 1'b0;
            end
            if (cmd.scan_rd)
            begin
                scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                scan_pend_reg <= 1'b1;
            end
            if (cmd.scan_cmp && scan_pend_reg && (rd_val > peak_reg))
            begin
                peak_reg <= rd_val;
            end
            if (cmd.emit_init)
            begin
                k_reg <= '0;
            end
            if (cmd.out_load)
            begin
                k_reg         <= k_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg    <= turn_rate;
            heading_reg <= heading_red;
            lift_reg    <= lift;
            h_start_reg <= prev_valid_reg ? prev_heading_reg : heading_red;
            h_reg       <= prev_valid_reg ? prev_heading_reg : heading_red;
        end
        if (cmd.filt_num)
        begin
            mag_reg <= hblm_pkg::MAG_W'(numer_adj);
            neg_reg <= numer[hblm_pkg::NUMER_W-1];
        end
        if (cmd.filt_mul)
        begin
            prod5_reg <= hblm_pkg::PROD5_W'(mag_reg) * hblm_pkg::PROD5_W'(hblm_pkg::DIV5_RECIP);
        end
        if (cmd.bin_mul)
        begin
            bin_prod_reg <= BIN_PROD_W'(h_reg + HALF_BIN) * BIN_PROD_W'(BIN_RECIP);
        end
        if (cmd.bin_rd)
        begin
            idx_reg <= bin_idx;
        end
        if (cmd.bin_rd || cmd.scan_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.walk_wr)
        begin
            mem[idx_reg] <= wr_val;
            h_reg        <= h_step;
        end
        if (cmd.emit_init)
        begin
            h_reg <= h_start_reg;
        end
        if (cmd.out_load)
        begin
            h_reg         <= h_step;
            bin_index_reg <= idx_reg;
            bin_lift_reg  <= rd_val;
            lift_peak_reg <= peak_reg[hblm_pkg::PEAK_W-1:0];
            left_reg      <= left;
            last_reg      <= status.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign bin_lift  = bin_lift_reg;
    assign lift_peak = lift_peak_reg;
    assign left_turn = left_reg;
    assign last      = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_wr |-> (n_reg < CNT_W'(WALK_MAX)))
        else $error("bin walk exceeded its length bound");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (k_reg < n_reg))
        else $error("more transactions emitted than bins written");

    a_peak_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_cmp && scan_pend_reg) |=> (peak_reg >= hblm_pkg::LIFT_FLOOR))
        else $error("peak lift fell below floor");

endmodule

@@ rtl/core/heading_binned_lift_map_core.sv @@
// Top level of the heading-binned lift map: controller plus datapath.
//
// Input channel (in_valid / in_stall) carries one fix per transaction:
// action, circling, fix_time, turn_rate, heading, lift. A fix is taken only
// while the block is idle; a clear (action = 1) or a rejected fix finishes
// in the cycle it is taken and produces nothing.
// Output channel (out_valid / out_stall) carries one transaction per bin
// written by the fix: bin_index, bin_lift, lift_peak, left_turn, last.
// An accepted fix writes N bins (N up to 19 at 36 bins) and is handled in
// steps: a read-modify-write of the single-port bin store per written bin,
// one store read per bin in the peak rescan, and a replay of the walk that
// presents each result. The first result appears after the rescan.
// The output register holds a result while out_stall is high; the
// sequencer waits on it and resumes when the slot frees.
// Reset empties the bin store (valid bits), zeros the filter and sets the
// previous fix as absent; the block is ready on the first cycle after it.
module heading_binned_lift_map_core #(
    parameter int NUM_BINS = hblm_pkg::NUM_BINS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic                                  circling,
    input  logic        [hblm_pkg::TIME_W-1:0]    fix_time,
    input  logic signed [hblm_pkg::RATE_W-1:0]    turn_rate,
    input  logic        [hblm_pkg::HEAD_W-1:0]    heading,
    input  logic signed [hblm_pkg::LIFT_W-1:0]    lift,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [$clog2(NUM_BINS)-1:0]    bin_index,
    output logic signed [hblm_pkg::LIFT_W-1:0]    bin_lift,
    output logic        [hblm_pkg::PEAK_W-1:0]    lift_peak,
    output logic                                  left_turn,
    output logic                                  last
);

    hblm_pkg::cmd_t    cmd;
    hblm_pkg::status_t status;

    hblm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    hblm_dp #(
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .circling  (circling),
        .fix_time  (fix_time),
        .turn_rate (turn_rate),
        .heading   (heading),
        .lift      (lift),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_index (bin_index),
        .bin_lift  (bin_lift),
        .lift_peak (lift_peak),
        .left_turn (left_turn),
        .last      (last)
    );

endmodule

@@ sim/heading_binned_lift_map_checker.sv @@
// Checker for the heading-binned lift map: predicts bin results and compares them.
`timescale 1ns / 100ps

module heading_binned_lift_map_checker #(
    parameter int NUM_BINS = hblm_pkg::NUM_BINS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  action,
    input  logic                                  circling,
    input  logic        [hblm_pkg::TIME_W-1:0]    fix_time,
    input  logic signed [hblm_pkg::RATE_W-1:0]    turn_rate,
    input  logic        [hblm_pkg::HEAD_W-1:0]    heading,
    input  logic signed [hblm_pkg::LIFT_W-1:0]    lift,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic        [$clog2(NUM_BINS)-1:0]    bin_index,
    input  logic signed [hblm_pkg::LIFT_W-1:0]    bin_lift,
    input  logic        [hblm_pkg::PEAK_W-1:0]    lift_peak,
    input  logic                                  left_turn,
    input  logic                                  last,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    fix_count,
    output int                                    clear_count,
    output int                                    ignored_count,
    output int                                    result_count
);

    localparam int TIME_W     = hblm_pkg::TIME_W;
    localparam int RATE_W     = hblm_pkg::RATE_W;
    localparam int HEAD_W     = hblm_pkg::HEAD_W;
    localparam int LIFT_W     = hblm_pkg::LIFT_W;
    localparam int FILT_W     = hblm_pkg::FILT_W;
    localparam int PEAK_W     = hblm_pkg::PEAK_W;
    localparam int FULL_TURN  = hblm_pkg::FULL_TURN;
    localparam int HALF_TURN  = hblm_pkg::HALF_TURN;
    localparam int LIFT_FLOOR = int'(hblm_pkg::LIFT_FLOOR);

    localparam int BIN_W    = FULL_TURN / NUM_BINS;
    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int WALK_MAX = HALF_TURN / BIN_W + 1;

    typedef struct packed {
        logic        [IDX_W-1:0]  idx;
        logic signed [LIFT_W-1:0] lift;
        logic        [PEAK_W-1:0] peak;
        logic                     left;
        logic                     last;
    } bin_result_t;

    bin_result_t              expected_bins[$];
    logic signed [FILT_W-1:0] rate_avg;
    logic signed [LIFT_W-1:0] lift_bins[NUM_BINS];
    logic        [TIME_W-1:0] last_time;
    int                       prev_hdg;
    logic                     have_heading;

    function automatic longint floor_div5(input longint n);
        if (n >= 0)
            return n / 5;
        return -((-n + 4) / 5);
    endfunction

    function automatic int bin_of(input int h);
        int idx;
        idx = (h + BIN_W / 2) / BIN_W;
        return (idx > NUM_BINS - 1) ? NUM_BINS - 1 : idx;
    endfunction

    function automatic int wrap_turn(input int d);
        int w;
        w = d;
        while (w > HALF_TURN)
            w -= FULL_TURN;
        while (w <= -HALF_TURN)
            w += FULL_TURN;
        return w;
    endfunction

    task automatic store_lift(input int idx, input logic signed [LIFT_W-1:0] lft,
                              input logic plain);
        int sum;
        if (plain || lift_bins[idx] == 0)
            lift_bins[idx] = lft;
        else
        begin
            sum = int'(lift_bins[idx]) + int'(lft);
            lift_bins[idx] = LIFT_W'(sum >>> 1);
        end
    endtask

    task automatic update_lift_map(input logic act, input logic circ,
                                   input logic [TIME_W-1:0] t,
                                   input logic signed [RATE_W-1:0] rate,
                                   input logic [HEAD_W-1:0] hdg,
                                   input logic signed [LIFT_W-1:0] lft);
        int          hd;
        int          h;
        int          d;
        int          peak;
        logic        left;
        logic        walking;
        int          written[$];
        bin_result_t r;
        if (act)
        begin
            foreach (lift_bins[i])
                lift_bins[i] = '0;
            rate_avg = '0;
            clear_count++;
        end
        else if (!circ || t <= last_time)
            ignored_count++;
        else
        begin
            hd = int'(hdg);
            if (hd >= FULL_TURN)
                hd -= FULL_TURN;
            if (rate_avg == 0)
                rate_avg = FILT_W'(int'(rate) * 256);
            else
                rate_avg = FILT_W'(floor_div5(4 * longint'(rate_avg) + 256 * longint'(rate)));
            left = (rate_avg < 0);
            if (!have_heading)
            begin
                store_lift(bin_of(hd), lft, 1'b1);
                written.push_back(bin_of(hd));
            end
            else
            begin
                h = prev_hdg;
                walking = 1'b1;
                while (walking && written.size() < WALK_MAX)
                begin
                    d = wrap_turn(hd - h);
                    walking = left ? (d < 0) : (d >= 0);
                    if (walking)
                    begin
                        store_lift(bin_of(h), lft, 1'b0);
                        written.push_back(bin_of(h));
                        h = left ? (h + FULL_TURN - BIN_W) % FULL_TURN
                                 : (h + BIN_W) % FULL_TURN;
                    end
                end
            end
            peak = LIFT_FLOOR;
            foreach (lift_bins[i])
                if (lift_bins[i] > peak)
                    peak = lift_bins[i];
            prev_hdg = hd;
            last_time = t;
            have_heading = 1'b1;
            fix_count++;
            foreach (written[k])
            begin
                r.idx  = IDX_W'(written[k]);
                r.lift = lift_bins[written[k]];
                r.peak = PEAK_W'(peak);
                r.left = left;
                r.last = (k == written.size() - 1);
                expected_bins.push_back(r);
            end
        end
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10)
            $display("%s", msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t want;
        if (!rst_n)
        begin
            foreach (lift_bins[i])
                lift_bins[i] = '0;
            rate_avg      = '0;
            last_time     = '0;
            prev_hdg      = 0;
            have_heading  = 1'b0;
            expected_bins.delete();
            fail_count    = 0;
            fix_count     = 0;
            clear_count   = 0;
            ignored_count = 0;
            result_count  = 0;
            pending      <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                update_lift_map(action, circling, fix_time, turn_rate, heading, lift);
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_bins.size() == 0)
                    note_failure($sformatf("unexpected bin result: bin %0d lift %0d max %0d",
                                           bin_index, bin_lift, lift_peak));
                else
                begin
                    want = expected_bins.pop_front();
                    if (bin_index !== want.idx || bin_lift !== want.lift ||
                        lift_peak !== want.peak || left_turn !== want.left ||
                        last !== want.last)
                        note_failure({
                            $sformatf("bin result mismatch: expected bin %0d lift %0d ",
                                      want.idx, want.lift),
                            $sformatf("max %0d left %0b last %0b, ",
                                      want.peak, want.left, want.last),
                            $sformatf("got bin %0d lift %0d max %0d left %0b last %0b",
                                      bin_index, bin_lift, lift_peak, left_turn, last)});
                end
            end
            pending <= expected_bins.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the heading-binned lift map: stimulus, stall pattern and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int TIME_W    = hblm_pkg::TIME_W;
    localparam int RATE_W    = hblm_pkg::RATE_W;
    localparam int HEAD_W    = hblm_pkg::HEAD_W;
    localparam int LIFT_W    = hblm_pkg::LIFT_W;
    localparam int PEAK_W    = hblm_pkg::PEAK_W;
    localparam int FULL_TURN = hblm_pkg::FULL_TURN;
    localparam int HALF_TURN = hblm_pkg::HALF_TURN;

    localparam int NUM_BINS       = hblm_pkg::NUM_BINS_DEF;
    localparam int IDX_W          = $clog2(NUM_BINS);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_FIXES   = 120;
    localparam int DRAIN_CYCLES   = 200;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     action    = 1'b0;
    logic                     circling  = 1'b0;
    logic        [TIME_W-1:0] fix_time  = '0;
    logic signed [RATE_W-1:0] turn_rate = '0;
    logic        [HEAD_W-1:0] heading   = '0;
    logic signed [LIFT_W-1:0] lift      = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic        [IDX_W-1:0]  bin_index;
    logic signed [LIFT_W-1:0] bin_lift;
    logic        [PEAK_W-1:0] lift_peak;
    logic                     left_turn;
    logic                     last;

    int fail_count;
    int pending;
    int fix_count;
    int clear_count;
    int ignored_count;
    int result_count;

    logic        calm       = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          useful;
    int          seq_len;
    int          rate_mag;
    int          lift_base;
    int          cur_heading;
    int          hv;
    int          step;
    int          rate_val;
    int          lift_val;
    logic        turn_left;
    logic        paused;
    logic [31:0] t;

    heading_binned_lift_map_core #(
        .NUM_BINS(NUM_BINS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .circling(circling),
        .fix_time(fix_time),
        .turn_rate(turn_rate),
        .heading(heading),
        .lift(lift),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_index(bin_index),
        .bin_lift(bin_lift),
        .lift_peak(lift_peak),
        .left_turn(left_turn),
        .last(last)
    );

    heading_binned_lift_map_checker #(
        .NUM_BINS(NUM_BINS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .circling(circling),
        .fix_time(fix_time),
        .turn_rate(turn_rate),
        .heading(heading),
        .lift(lift),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_index(bin_index),
        .bin_lift(bin_lift),
        .lift_peak(lift_peak),
        .left_turn(left_turn),
        .last(last),
        .fail_count(fail_count),
        .pending(pending),
        .fix_count(fix_count),
        .clear_count(clear_count),
        .ignored_count(ignored_count),
        .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (calm)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_fix(input logic act, input logic circ, input logic [31:0] tm,
                            input int rate, input int hdg, input int lft);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action    <= act;
        circling  <= circ;
        fix_time  <= tm;
        turn_rate <= RATE_W'(rate);
        heading   <= HEAD_W'(hdg);
        lift      <= LIFT_W'(lft);
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fix(1'b0, 1'b1, 32'd0, 0, 0, 0);
        send_fix(1'b0, 1'b0, 32'd100, 5, 100, 100);
        send_fix(1'b0, 1'b1, 32'd10, 0, 0, 32767);
        send_fix(1'b0, 1'b1, 32'd20, 32767, 1800, -32768);
        send_fix(1'b0, 1'b1, 32'd20, 10, 100, 5);
        send_fix(1'b0, 1'b1, 32'd15, 10, 100, 5);
        send_fix(1'b1, 1'b0, $urandom, 0, 0, 0);
        send_fix(1'b0, 1'b1, 32'd30, -32768, 3599, 1000);
        send_fix(1'b0, 1'b1, 32'd40, -100, 3000, -3);
        send_fix(1'b0, 1'b1, 32'd50, -100, 2900, 0);
        send_fix(1'b0, 1'b1, 32'd60, -100, 2800, 7);
        send_fix(1'b1, 1'b1, 32'd65, 0, 0, 0);
        send_fix(1'b0, 1'b1, 32'd70, 100, 1000, 2000);
        send_fix(1'b0, 1'b1, 32'd80, -400, 1000, -2000);
        send_fix(1'b0, 1'b1, 32'd90, 50, 1000, -5);
        send_fix(1'b0, 1'b1, 32'd100, 50, 1000, 0);
        send_fix(1'b0, 1'b1, 32'd110, -32768, 3550, -1);
        send_fix(1'b0, 1'b1, 32'd120, -32768, 4095, 32767);
        send_fix(1'b0, 1'b1, 32'd130, 32767, 3550, -32768);

        wait_drained();

        useful = 0;
        paused = 1'b0;
        t = 32'd1000;
        cur_heading = $urandom_range(0, FULL_TURN - 1);
        while (useful < RANDOM_FIXES)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_fix(1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                         $urandom);
                useful++;
            end
            calm <= ($urandom_range(0, 5) == 0);
            turn_left = 1'($urandom_range(0, 1));
            rate_mag = ($urandom_range(0, 9) == 0) ? $urandom_range(4000, 32767)
                                                   : $urandom_range(20, 3000);
            lift_base = $urandom_range(0, 8000);
            lift_base -= 3000;
            seq_len = $urandom_range(4, 16);
            for (int j = 0; j < seq_len; j++)
            begin
                case ($urandom_range(0, 11))
                    0: send_fix(1'b0, 1'b0, $urandom, $urandom, $urandom_range(0, 4095),
                                $urandom);
                    1: send_fix(1'b0, 1'b1, $urandom_range(0, t), $urandom,
                                $urandom_range(0, 4095), $urandom);
                    2:
                    begin
                        t += $urandom_range(1, 1500);
                        cur_heading = $urandom_range(0, FULL_TURN - 1);
                        send_fix(1'b0, 1'b1, t, $urandom, $urandom_range(0, 4095), $urandom);
                        useful++;
                    end
                    default:
                    begin
                        t += $urandom_range(1, 1500);
                        step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, HALF_TURN)
                                                             : $urandom_range(0, 350);
                        cur_heading = turn_left ? (cur_heading + FULL_TURN - step) % FULL_TURN
                                                : (cur_heading + step) % FULL_TURN;
                        hv = cur_heading;
                        if (hv < 496 && $urandom_range(0, 7) == 0)
                            hv += FULL_TURN;
                        rate_val = turn_left ? -rate_mag : rate_mag;
                        rate_val = clamp16(rate_val + $urandom_range(0, 40) - 20);
                        if ($urandom_range(0, 7) == 0)
                            lift_val = clamp16(int'($signed(16'($urandom))));
                        else
                            lift_val = clamp16(lift_base + $urandom_range(0, 4000) - 2000);
                        send_fix(1'b0, 1'b1, t, rate_val, hv, lift_val);
                        useful++;
                    end
                endcase
            end
            if (!paused && useful >= RANDOM_FIXES / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end
        calm <= 1'b0;
        send_fix(1'b0, 1'b1, 32'hFFFF_FFFF, 200, cur_heading, 32767);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d accepted fixes, %0d clears and %0d ignored fixes,",
                 fix_count, clear_count, ignored_count);
        $display("with %0d bin results checked against the predicted lift map.", result_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/hblm_pkg.sv
rtl/core/hblm_ctrl.sv
rtl/core/hblm_dp.sv
rtl/core/heading_binned_lift_map_core.sv
sim/heading_binned_lift_map_checker.sv
sim/tb.sv
